/* hdl/stdg_pkg.sv */
// ----------------------------------------------------------------------------
// stdg_pkg
// Shared widths and traffic pattern codes for the destination generator.
// ----------------------------------------------------------------------------
package stdg_pkg;

  // field widths
  localparam int PORT_W = 7;   // port count register, N
  localparam int PAT_W  = 3;   // traffic pattern register
  localparam int SRC_W  = 6;   // source port
  localparam int WORD_W = 31;  // random word
  localparam int DST_W  = 6;   // destination port
  localparam int DIV_W  = 14;  // quasi-diagonal dividend, below N*(N-1)
  localparam int CNT_W  = 3;   // halving threshold counts

  typedef logic [PAT_W-1:0] pattern_t;

  // traffic pattern codes; every other code selects quasi diagonal
  localparam pattern_t PAT_UNIFORM = 3'd0;
  localparam pattern_t PAT_DIAG    = 3'd1;
  localparam pattern_t PAT_LOGDIAG = 3'd2;
  localparam pattern_t PAT_QUASI   = 3'd3;
  localparam pattern_t PAT_SKEWED  = 3'd4;

  // register byte addresses
  localparam logic [2:0] ADDR_PORT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_PATTERN    = 3'd4;

endpackage

/* hdl/switch_traffic_destination_generator.sv */
// ----------------------------------------------------------------------------
// switch_traffic_destination_generator
// Picks a destination port for switch test traffic from a source port and
// a 31-bit random word, following a selectable traffic pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_source_port and in_random_word with start high;
//   the item transfers at the rising edge where start is high and busy is
//   low. busy stays low, so one item can transfer on every clock.
//   Result channel: out_valid pulses for one cycle with out_destination_port
//   after five register stages (scale multiply, threshold compares and
//   quasi-diagonal product, two halves of the quasi-diagonal quotient, final
//   modulo add). The receiver cannot stall, so results leave the pipeline in
//   order, one per accepted item.
//   Configuration: APB-style port, port_count at byte address 0 (reset 32),
//   traffic_pattern at byte address 4 (reset 0). Write only while no item is
//   in flight. pready is always high.
//   Reset: synchronous rst_n clears the pipeline valid bits and restores the
//   register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module switch_traffic_destination_generator
  import stdg_pkg::*;
#(
  parameter int MAX_PORTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  logic [SRC_W-1:0]  in_source_port,
  input  logic [WORD_W-1:0] in_random_word,
  // result channel
  output logic              out_valid,
  output logic [DST_W-1:0]  out_destination_port,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // largest usable N: limited by the parameter and by the register width
  localparam logic [PORT_W-1:0] N_CAP =
    (MAX_PORTS > (2**PORT_W - 1)) ? PORT_W'(2**PORT_W - 1) : PORT_W'(MAX_PORTS);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [PORT_W-1:0] port_count_r;
  pattern_t          traffic_pattern_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // take a register write at the end of the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_count_r      <= PORT_W'(32);
      traffic_pattern_r <= PAT_UNIFORM;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_PATTERN[2]) begin
        traffic_pattern_r <= pwdata[PAT_W-1:0];
      end else begin
        port_count_r <= pwdata[PORT_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == ADDR_PATTERN[2]) begin
      prdata = {{(32-PAT_W){1'b0}}, traffic_pattern_r};
    end else begin
      prdata = {{(32-PORT_W){1'b0}}, port_count_r};
    end
  end

  // effective port count, saturated to 1..N_CAP
  logic [PORT_W-1:0] n_w;
  logic [PORT_W-1:0] n_m1_w;

  always_comb begin
    if (port_count_r == '0) begin
      n_w = PORT_W'(1);
    end else if (port_count_r > N_CAP) begin
      n_w = N_CAP;
    end else begin
      n_w = port_count_r;
    end
  end

  assign n_m1_w = n_w - PORT_W'(1);

  // every cycle can take an item
  assign busy = 1'b0;

  // small residue of a 3-bit value by n
  function automatic logic [CNT_W-1:0] mod_small(input logic [CNT_W-1:0] v,
                                                 input logic [PORT_W-1:0] n);
    logic [PORT_W+CNT_W-1:0] rem;
    logic [PORT_W+CNT_W-1:0] dv;
    rem = (PORT_W+CNT_W)'(v);
    for (int i = CNT_W - 1; i >= 0; i--) begin
      dv = (PORT_W+CNT_W)'(n) << i;
      if (rem >= dv) begin
        rem = rem - dv;
      end
    end
    return rem[CNT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // stage 1: scale the random word, first half of source mod N
  // --------------------------------------------------------------------------
  localparam int PROD_W = WORD_W + PORT_W;
  localparam int SH_W   = SRC_W + PORT_W;

  logic                 in_xfer;
  logic [PROD_W-1:0]    prod_w;
  logic [PORT_W-1:0]    s1_c_nxt;
  logic [SRC_W-1:0]     s1_src_nxt;
  logic [SH_W-1:0]      s1_rem;
  logic                 s1_vld_r;
  logic [PORT_W-1:0]    s1_c_r;
  logic [SRC_W-1:0]     s1_src_r;

  assign in_xfer  = start && !busy;
  assign prod_w   = PROD_W'(in_random_word) * PROD_W'(n_w);
  assign s1_c_nxt = prod_w[PROD_W-1:WORD_W];

  always_comb begin
    s1_rem = SH_W'(in_source_port);
    for (int i = SRC_W - 1; i >= SRC_W / 2; i--) begin
      if (s1_rem >= (SH_W'(n_w) << i)) begin
        s1_rem = s1_rem - (SH_W'(n_w) << i);
      end
    end
    s1_src_nxt = s1_rem[SRC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    s1_c_r   <= s1_c_nxt;
    s1_src_r <= s1_src_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 2: finish source mod N, threshold compares, quasi-diagonal product
  // --------------------------------------------------------------------------
  localparam int CMP_W = PORT_W + 7;

  logic [SH_W-1:0]     s2_rem;
  logic [SRC_W-1:0]    s2_src_nxt;
  logic                s2_qlo_nxt;
  logic                s2_dlo_nxt;
  logic [CNT_W-1:0]    s2_klog_nxt;
  logic [CNT_W-1:0]    s2_ksk_nxt;
  logic [PORT_W:0]     s2_t;
  logic [DIV_W-1:0]    s2_d_nxt;
  logic [CMP_W-1:0]    s2_lhs;
  logic [CMP_W-1:0]    s2_rhs;
  logic                s2_vld_r;
  logic [SRC_W-1:0]    s2_src_r;
  logic [PORT_W-1:0]   s2_c_r;
  logic                s2_qlo_r;
  logic                s2_dlo_r;
  logic [CNT_W-1:0]    s2_klog_r;
  logic [CNT_W-1:0]    s2_ksk_r;
  logic [DIV_W-1:0]    s2_d_r;

  // finish the source residue
  always_comb begin
    s2_rem = SH_W'(s1_src_r);
    for (int i = SRC_W / 2 - 1; i >= 0; i--) begin
      if (s2_rem >= (SH_W'(n_w) << i)) begin
        s2_rem = s2_rem - (SH_W'(n_w) << i);
      end
    end
    s2_src_nxt = s2_rem[SRC_W-1:0];
  end

  // count halving thresholds c*2^m >= N*(2^m - 1)
  always_comb begin
    s2_klog_nxt = '0;
    s2_ksk_nxt  = '0;
    for (int m = 1; m <= 6; m++) begin
      s2_lhs = CMP_W'(s1_c_r) << m;
      s2_rhs = (CMP_W'(n_w) << m) - CMP_W'(n_w);
      if (s2_lhs >= s2_rhs) begin
        if (m <= 5) begin
          s2_klog_nxt = s2_klog_nxt + CNT_W'(1);
        end
        s2_ksk_nxt = s2_ksk_nxt + CNT_W'(1);
      end
    end
  end

  // lower-half and lower-two-thirds tests and quasi-diagonal dividend (2c - N)(N - 1)
  assign s2_qlo_nxt = {s1_c_r, 1'b0} < (PORT_W+1)'(n_w);
  assign s2_dlo_nxt = ((PORT_W+2)'(s1_c_r) + (PORT_W+2)'({s1_c_r, 1'b0}))
                      < (PORT_W+2)'({n_w, 1'b0});
  assign s2_t       = {s1_c_r, 1'b0} - (PORT_W+1)'(n_w);
  assign s2_d_nxt   = DIV_W'(s2_t[PORT_W-1:0]) * DIV_W'(n_m1_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_src_r  <= s2_src_nxt;
    s2_c_r    <= s1_c_r;
    s2_qlo_r  <= s2_qlo_nxt;
    s2_dlo_r  <= s2_dlo_nxt;
    s2_klog_r <= s2_klog_nxt;
    s2_ksk_r  <= s2_ksk_nxt;
    s2_d_r    <= s2_qlo_nxt ? '0 : s2_d_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 3: upper quotient bits of d / N, small offsets mod N
  // --------------------------------------------------------------------------
  localparam int Q_W = PORT_W;

  logic [DIV_W-1:0]   s3_rem_nxt;
  logic [Q_W-1:0]     s3_q_nxt;
  logic [CNT_W-1:0]   s3_klm_nxt;
  logic [CNT_W-1:0]   s3_ksm_nxt;
  logic               s3_dg_nxt;
  logic               s3_vld_r;
  logic [SRC_W-1:0]   s3_src_r;
  logic [PORT_W-1:0]  s3_c_r;
  logic               s3_qlo_r;
  logic               s3_dg_r;
  logic [CNT_W-1:0]   s3_klm_r;
  logic [CNT_W-1:0]   s3_ksm_r;
  logic [DIV_W-1:0]   s3_rem_r;
  logic [Q_W-1:0]     s3_q_r;

  // restoring divide, quotient bits Q_W-1 down to Q_W/2
  always_comb begin
    s3_rem_nxt = s2_d_r;
    s3_q_nxt   = '0;
    for (int i = Q_W - 1; i >= Q_W / 2; i--) begin
      if (s3_rem_nxt >= (DIV_W'(n_w) << i)) begin
        s3_rem_nxt  = s3_rem_nxt - (DIV_W'(n_w) << i);
        s3_q_nxt[i] = 1'b1;
      end
    end
  end

  assign s3_klm_nxt = mod_small(s2_klog_r, n_w);
  assign s3_ksm_nxt = mod_small(s2_ksk_r + CNT_W'(1), n_w);
  assign s3_dg_nxt  = !s2_dlo_r && (n_w != PORT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_src_r <= s2_src_r;
    s3_c_r   <= s2_c_r;
    s3_qlo_r <= s2_qlo_r;
    s3_dg_r  <= s3_dg_nxt;
    s3_klm_r <= s3_klm_nxt;
    s3_ksm_r <= s3_ksm_nxt;
    s3_rem_r <= s3_rem_nxt;
    s3_q_r   <= s3_q_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 4: lower quotient bits, pick base and offset for the pattern
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0]   s4_rem;
  logic [Q_W-1:0]     s4_q;
  logic [Q_W:0]       s4_j;
  logic [PORT_W-1:0]  s4_jc;
  logic [PORT_W-1:0]  s4_base_nxt;
  logic [PORT_W-1:0]  s4_add_nxt;
  logic               s4_vld_r;
  logic [PORT_W-1:0]  s4_base_r;
  logic [PORT_W-1:0]  s4_add_r;

  always_comb begin
    s4_rem = s3_rem_r;
    s4_q   = s3_q_r;
    for (int i = Q_W / 2 - 1; i >= 0; i--) begin
      if (s4_rem >= (DIV_W'(n_w) << i)) begin
        s4_rem  = s4_rem - (DIV_W'(n_w) << i);
        s4_q[i] = 1'b1;
      end
    end
  end

  // j = d / N + 1, capped at N - 1
  always_comb begin
    s4_j = (Q_W+1)'(s4_q) + (Q_W+1)'(1);
    if (s4_j > (Q_W+1)'(n_m1_w)) begin
      s4_jc = n_m1_w;
    end else begin
      s4_jc = s4_j[PORT_W-1:0];
    end
  end

  // both base and offset are below N
  always_comb begin
    case (traffic_pattern_r)
      PAT_UNIFORM: begin
        s4_base_nxt = s3_c_r;
        s4_add_nxt  = '0;
      end
      PAT_DIAG: begin
        s4_base_nxt = PORT_W'(s3_src_r);
        s4_add_nxt  = PORT_W'(s3_dg_r);
      end
      PAT_LOGDIAG: begin
        s4_base_nxt = PORT_W'(s3_src_r);
        s4_add_nxt  = PORT_W'(s3_klm_r);
      end
      PAT_SKEWED: begin
        s4_base_nxt = '0;
        s4_add_nxt  = PORT_W'(s3_ksm_r);
      end
      default: begin
        s4_base_nxt = PORT_W'(s3_src_r);
        s4_add_nxt  = s3_qlo_r ? '0 : s4_jc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_base_r <= s4_base_nxt;
    s4_add_r  <= s4_add_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 5: wrap the sum into 0..N-1 and drive the result
  // --------------------------------------------------------------------------
  logic [PORT_W:0]    s5_sum;
  logic [PORT_W:0]    s5_wrap;
  logic [DST_W-1:0]   s5_dst_nxt;
  logic               out_valid_r;
  logic [DST_W-1:0]   out_dst_r;

  always_comb begin
    s5_sum = (PORT_W+1)'(s4_base_r) + (PORT_W+1)'(s4_add_r);
    if (s5_sum >= (PORT_W+1)'(n_w)) begin
      s5_wrap = s5_sum - (PORT_W+1)'(n_w);
    end else begin
      s5_wrap = s5_sum;
    end
    s5_dst_nxt = s5_wrap[DST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_dst_r <= s5_dst_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_destination_port = out_dst_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##5 out_valid)
    else $error("accepted item did not produce a result after 5 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(in_xfer))
    else $error("pipeline stage 1 valid without an input transfer");

  a_dst_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (n_w <= PORT_W'(2**DST_W))) |-> (PORT_W'(out_destination_port) < n_w))
    else $error("destination port not below the port count");

endmodule

/* dv/switch_traffic_destination_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_traffic_destination_generator_test
// Self-checking bench for the switch traffic destination generator. A local
// predictor mirrors the port count and pattern registers and computes the
// destination of every accepted item; a monitor compares each result strobe
// against the oldest pending destination. Directed items cover register
// defaults, port count saturation and every pattern code, then bursty random
// traffic runs over many register settings with boundary-heavy random words.
// ----------------------------------------------------------------------------
module switch_traffic_destination_generator_test;
  import stdg_pkg::*;

  localparam int MAX_PORTS  = 64;
  localparam int PIPE_DEPTH = 5;
  localparam int MAX_REPORTS = 10;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [SRC_W-1:0]  in_source_port;
  logic [WORD_W-1:0] in_random_word;
  logic              out_valid;
  logic [DST_W-1:0]  out_destination_port;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // register shadow used by the predictor
  logic [PORT_W-1:0] shadow_port_count;
  pattern_t          shadow_pattern;

  // destinations still owed by the block, oldest first
  logic [DST_W-1:0]  pending_destinations[$];
  int unsigned       mismatches;

  switch_traffic_destination_generator #(
    .MAX_PORTS(MAX_PORTS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_source_port      (in_source_port),
    .in_random_word      (in_random_word),
    .out_valid           (out_valid),
    .out_destination_port(out_destination_port),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Destination predictor
  // ---------------------------------------------------------------------------

  // saturate the port count register to 1..MAX_PORTS
  function automatic longint unsigned ports_in_use();
    longint unsigned n;
    n = 64'(shadow_port_count);
    if (n < 1) n = 1;
    if (n > MAX_PORTS) n = MAX_PORTS;
    return n;
  endfunction

  // count how many of the thresholds N*(1 - 2^-m), m = 1..levels, slot c reaches
  function automatic longint unsigned halving_steps(longint unsigned c, longint unsigned n,
                                                    int unsigned levels);
    longint unsigned steps;
    longint unsigned p;
    steps = 0;
    for (int unsigned m = 1; m <= levels; m++) begin
      p = longint'(1) << m;
      if (c * p >= n * (p - 1)) steps++;
    end
    return steps;
  endfunction

  function automatic logic [DST_W-1:0] predict_destination(logic [SRC_W-1:0] src,
                                                           logic [WORD_W-1:0] word);
    longint unsigned n, s, w, c, d, j, r;
    n = ports_in_use();
    s = 64'(src) % n;
    w = 64'(word);
    c = (w * n) >> 31;
    case (shadow_pattern)
      PAT_UNIFORM: r = c;
      PAT_DIAG:    r = (3 * c < 2 * n) ? s : (s + 1) % n;
      PAT_LOGDIAG: r = (s + halving_steps(c, n, 5)) % n;
      PAT_SKEWED:  r = (halving_steps(c, n, 6) + 1) % n;
      default: begin
        // quasi diagonal: lower half stays home, upper half spreads over others
        if (2 * c < n) begin
          r = s;
        end else begin
          d = 2 * c * (n - 1) - n * (n - 1);
          j = d / n + 1;
          if (j > n - 1) j = n - 1;
          r = (s + j) % n;
        end
      end
    endcase
    return r[DST_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint unsigned expected_value,
                                 longint unsigned actual_value);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
               expected_value, actual_value);
  endtask

  // compare every result strobe against the oldest pending destination
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_destinations.size() == 0) begin
        report_mismatch("unexpected destination_port", 0, 64'(out_destination_port));
      end else if (out_destination_port !== pending_destinations[0]) begin
        report_mismatch("destination_port", 64'(pending_destinations[0]),
                        64'(out_destination_port));
        void'(pending_destinations.pop_front());
      end else begin
        void'(pending_destinations.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // present one item and hold it until it transfers
  task automatic send_item(logic [SRC_W-1:0] src, logic [WORD_W-1:0] word);
    @(negedge clk);
    start          = 1'b1;
    in_source_port = src;
    in_random_word = word;
    do @(posedge clk); while (busy);
    pending_destinations.push_back(predict_destination(src, word));
  endtask

  // drop start for a number of cycles, with noise on the item fields
  task automatic sender_gap(int unsigned cycles);
    @(negedge clk);
    start          = 1'b0;
    in_source_port = SRC_W'($urandom);
    in_random_word = WORD_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off until every pending destination has come out, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_destinations.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------

  task automatic read_register(logic [2:0] addr, logic [31:0] expected_value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== expected_value)
      report_mismatch("register read", 64'(expected_value), 64'(prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write one register while idle, update the shadow and read it back
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    logic [31:0] readback;
    drain_results();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_PORT_COUNT) begin
      shadow_port_count = value[PORT_W-1:0];
      readback = 32'(shadow_port_count);
    end else begin
      shadow_pattern = value[PAT_W-1:0];
      readback = 32'(shadow_pattern);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    pwdata  = $urandom;
    read_register(addr, readback);
  endtask

  // set both registers; upper data bits carry noise the block must ignore
  task automatic configure(logic [PORT_W-1:0] ports, pattern_t pattern);
    logic [31:0] noise;
    noise = $urandom;
    write_register(ADDR_PORT_COUNT, {noise[31:PORT_W], ports});
    noise = $urandom;
    write_register(ADDR_PATTERN, {noise[31:PAT_W], pattern});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // random word biased toward slot boundaries and bit extremes
  function automatic logic [WORD_W-1:0] pick_word();
    longint unsigned n, t, w;
    n = ports_in_use();
    case ($urandom_range(2))
      0: w = 64'($urandom);
      1: begin
        // land on the first word of a random slot, or the last word below it
        t = 64'($urandom_range(32'(n - 1)));
        w = ((t << 31) + n - 1) / n;
        if ($urandom_range(1) && w > 0) w--;
      end
      default: begin
        w = longint'(1) << $urandom_range(WORD_W - 1);
        if ($urandom_range(1)) w = ~w;
      end
    endcase
    return w[WORD_W-1:0];
  endfunction

  // source ports mostly below N, sometimes anywhere
  function automatic logic [SRC_W-1:0] pick_source();
    longint unsigned n;
    n = ports_in_use();
    if ($urandom_range(3) == 0) return SRC_W'($urandom);
    return SRC_W'($urandom_range(32'(n - 1)));
  endfunction

  // send items in bursts of random length, mostly with random gaps between them
  task automatic send_bursts(int unsigned items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 16);
      for (int unsigned k = 0; k < burst && sent < items; k++) begin
        send_item(pick_source(), pick_word());
        sent++;
      end
      if ($urandom_range(3) != 0) sender_gap($urandom_range(1, 8));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // register defaults after reset, and items run at those defaults
  task automatic test_reset_defaults();
    read_register(ADDR_PORT_COUNT, 32'd32);
    read_register(ADDR_PATTERN, 32'(PAT_UNIFORM));
    send_item('0, '0);
    send_item('1, '1);
    send_item(6'd31, 31'h4000_0000);
  endtask

  // port count of one, zero, above the limit, two and the maximum
  task automatic test_port_count_extremes();
    configure(7'd1, PAT_SKEWED);
    send_item('1, '1);
    configure(7'd0, PAT_UNIFORM);
    send_item(6'd17, '1);
    configure('1, PAT_LOGDIAG);
    send_item('1, '1);
    configure(7'd2, PAT_DIAG);
    send_item('1, 31'h5555_5555);
    configure(7'd64, PAT_QUASI);
    send_item('1, '1);
    send_item('0, 31'h4000_0000);
  endtask

  // every pattern code at the diagonal and quasi-diagonal boundaries
  task automatic test_each_pattern();
    for (int p = 0; p < (1 << PAT_W); p++) begin
      configure(7'd64, pattern_t'(p));
      send_item(6'd1, 31'h5555_5555);
      send_item(6'd62, 31'h4000_0000);
    end
  endtask

  // bursty random traffic over many register settings
  task automatic test_random_traffic();
    logic [PORT_W-1:0] ports;
    logic [PORT_W-1:0] port_choices[8];
    port_choices = '{7'd2, 7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65, 7'd33};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 8) begin
        ports = port_choices[phase];
      end else begin
        ports = ($urandom_range(1) == 0) ? PORT_W'($urandom_range(2, 9)) : PORT_W'($urandom);
      end
      configure(ports, (phase < 8) ? pattern_t'(phase) : pattern_t'($urandom));
      send_bursts(30);
    end
  endtask

  // hold the sender until everything is out, then resume
  task automatic test_pause_until_drained();
    configure(7'd48, PAT_LOGDIAG);
    send_bursts(10);
    drain_results();
    send_bursts(10);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_source_port    = '0;
    in_random_word    = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    shadow_port_count = 7'd32;
    shadow_pattern    = PAT_UNIFORM;
    mismatches        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_port_count_extremes();
    test_each_pattern();
    test_random_traffic();
    test_pause_until_drained();

    drain_results();
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (mismatches == 0 && pending_destinations.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
